// File: rtl/aabbxf_pkg.sv
// Shared types and constants for the bounding box transform block.
// Used by the channel interfaces, the per-axis datapath and the top level.
// No dependencies.
package aabbxf_pkg;

   // Number formats: coordinates Q16.16, coefficients Q4.16.
   localparam int COORD_WIDTH    = 32;
   localparam int COEF_WIDTH     = 20;
   localparam int FRAC_BITS      = 16;
   localparam int AXES           = 3;
   localparam int ROW_WIDTH      = AXES * COEF_WIDTH;
   localparam int CSR_ADDR_WIDTH = 3;

   // Exact product, shifted term, and sum of three terms plus translation.
   localparam int PROD_WIDTH = COORD_WIDTH + COEF_WIDTH;
   localparam int TERM_WIDTH = PROD_WIDTH - FRAC_BITS;
   localparam int SUM_WIDTH  = TERM_WIDTH + 2;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [COEF_WIDTH-1:0]  coef_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic signed [TERM_WIDTH-1:0]  term_type;
   typedef logic signed [SUM_WIDTH-1:0]   sum_type;

   // Saturation bounds of a coordinate, at the width of the sum.
   localparam sum_type COORD_MAX = SUM_WIDTH'({1'b0, {(COORD_WIDTH-1){1'b1}}});
   localparam sum_type COORD_MIN = -COORD_MAX - sum_type'(1);

   // Unit coefficient for the identity matrix at reset.
   localparam coef_type COEF_ONE = coef_type'(1) <<< FRAC_BITS;

   // Configuration register indexes.
   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_ROW0    = 3'd0,
      CSR_ROW1    = 3'd1,
      CSR_ROW2    = 3'd2,
      CSR_SHIFT_X = 3'd3,
      CSR_SHIFT_Y = 3'd4,
      CSR_SHIFT_Z = 3'd5
   } csr_index_type;

   // Input beat: the box given by its two corners.
   typedef struct packed {
      coord_type box_min_x;
      coord_type box_min_y;
      coord_type box_min_z;
      coord_type box_max_x;
      coord_type box_max_y;
      coord_type box_max_z;
   } box_type;

   // Result beat: the transformed box.
   typedef struct packed {
      coord_type out_min_x;
      coord_type out_min_y;
      coord_type out_min_z;
      coord_type out_max_x;
      coord_type out_max_y;
      coord_type out_max_z;
   } result_type;

   // Load strobes for the datapath stages behind the input register.
   typedef struct packed {
      logic load2;
      logic load3;
      logic load4;
   } pipe_ctl_type;

endpackage

// File: rtl/aabbxf_ifs.sv
// Valid/ready channel interfaces for the box input and the result output.
// Depends on aabbxf_pkg for the payload types.
interface aabbxf_req_if;
   import aabbxf_pkg::*;

   logic    valid;
   logic    ready;
   box_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface aabbxf_rsp_if;
   import aabbxf_pkg::*;

   logic       valid;
   logic       ready;
   result_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/aabbxf_axis.sv
// Datapath for one output axis: products, per-term min/max, sum and saturation.
// Depends on aabbxf_pkg; stage strobes come from the top level.
module aabbxf_axis (
   input  logic                   clock,
   input  aabbxf_pkg::pipe_ctl_type ctl,
   input  aabbxf_pkg::coord_type  lo [aabbxf_pkg::AXES],
   input  aabbxf_pkg::coord_type  hi [aabbxf_pkg::AXES],
   input  aabbxf_pkg::coef_type   coef [aabbxf_pkg::AXES],
   input  aabbxf_pkg::coord_type  shift,
   output aabbxf_pkg::coord_type  out_min,
   output aabbxf_pkg::coord_type  out_max
);
   import aabbxf_pkg::*;

   prod_type  prod_lo_in [AXES];
   prod_type  prod_hi_in [AXES];
   prod_type  prod_lo_ff [AXES];
   prod_type  prod_hi_ff [AXES];
   term_type  tmin_in [AXES];
   term_type  tmax_in [AXES];
   term_type  tmin_ff [AXES];
   term_type  tmax_ff [AXES];
   sum_type   sum_min;
   sum_type   sum_max;
   coord_type out_min_in;
   coord_type out_max_in;
   coord_type out_min_ff;
   coord_type out_max_ff;

   // Each input coordinate meets one coefficient; both corner values are multiplied.
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         prod_lo_in[i] = prod_type'(lo[i]) * prod_type'(coef[i]);
         prod_hi_in[i] = prod_type'(hi[i]) * prod_type'(coef[i]);
      end
   end

   // Every term depends on one coordinate only, so the extreme corner of the
   // sum picks the smaller or larger floored product of each term alone.
   always_comb begin
      term_type a;
      term_type b;
      for (int i = 0; i < AXES; i++) begin
         a = TERM_WIDTH'(prod_lo_ff[i] >>> FRAC_BITS);
         b = TERM_WIDTH'(prod_hi_ff[i] >>> FRAC_BITS);
         tmin_in[i] = (a < b) ? a : b;
         tmax_in[i] = (a < b) ? b : a;
      end
   end

   // Sum with the translation, then clamp; clamping is monotonic, so the
   // clamped extremes equal the extremes of the clamped corners.
   always_comb begin
      sum_min = sum_type'(shift) + sum_type'(tmin_ff[0]) + sum_type'(tmin_ff[1])
              + sum_type'(tmin_ff[2]);
      sum_max = sum_type'(shift) + sum_type'(tmax_ff[0]) + sum_type'(tmax_ff[1])
              + sum_type'(tmax_ff[2]);
      if (sum_min > COORD_MAX) begin
         out_min_in = COORD_WIDTH'(COORD_MAX);
      end else if (sum_min < COORD_MIN) begin
         out_min_in = COORD_WIDTH'(COORD_MIN);
      end else begin
         out_min_in = COORD_WIDTH'(sum_min);
      end
      if (sum_max > COORD_MAX) begin
         out_max_in = COORD_WIDTH'(COORD_MAX);
      end else if (sum_max < COORD_MIN) begin
         out_max_in = COORD_WIDTH'(COORD_MIN);
      end else begin
         out_max_in = COORD_WIDTH'(sum_max);
      end
   end

   // Payload registers; valid bits live in the top level.
   always_ff @(posedge clock) begin
      if (ctl.load2) begin
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
      end
      if (ctl.load3) begin
         tmin_ff <= tmin_in;
         tmax_ff <= tmax_in;
      end
      if (ctl.load4) begin
         out_min_ff <= out_min_in;
         out_max_ff <= out_max_in;
      end
   end

   assign out_min = out_min_ff;
   assign out_max = out_max_ff;

endmodule

// File: rtl/affine_bounding_box_transform.sv
// Top level of the affine bounding box transform.
// Depends on aabbxf_pkg, aabbxf_ifs (channels) and aabbxf_axis (one per axis).
//
// Usage:
//   A box arrives as one beat on req_ch (min and max corners, Q16.16). The
//   transformed box leaves as one beat on rsp_ch: each corner is multiplied
//   as a row vector by the 3x3 coefficient matrix, the translation is added,
//   and the per-axis minimum and maximum over the eight corners is returned,
//   saturated to 32 bits.
//   The user must write the matrix rows and the translation through the csr_
//   port (write enable, index, data) while no beat is in flight; the block
//   itself does not enforce this. An accepted request beat passes through
//   the input, product, term and result registers to the response beat.
//   Throughput is one beat per cycle while the receiver keeps up, set by the
//   four-stage pipeline, one multiplier per coordinate and coefficient pair.
//   When the receiver stalls, the result register holds its beat and the
//   stages behind it keep filling; req_ch.ready falls only once all four
//   stages hold beats.
//   Reset empties the pipeline and loads the identity matrix and a zero
//   translation.
module affine_bounding_box_transform (
   input  logic                                   clock,
   input  logic                                   reset,
   aabbxf_req_if.sink                             req_ch,
   aabbxf_rsp_if.source                           rsp_ch,
   input  logic                                   csr_we,
   input  logic [aabbxf_pkg::CSR_ADDR_WIDTH-1:0]  csr_addr,
   input  logic [aabbxf_pkg::ROW_WIDTH-1:0]       csr_wdata
);
   import aabbxf_pkg::*;

   coef_type     coef_ff [AXES][AXES];
   coord_type    shift_ff [AXES];
   coord_type    lo_ff [AXES];
   coord_type    hi_ff [AXES];
   coord_type    out_min [AXES];
   coord_type    out_max [AXES];
   coef_type     col [AXES][AXES];
   logic         v1_ff, v2_ff, v3_ff, v4_ff;
   logic         rdy1, rdy2, rdy3, rdy4;
   logic         load1;
   pipe_ctl_type ctl;

   // Configuration registers; only the used coefficient bits are kept.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            for (int j = 0; j < AXES; j++) begin
               coef_ff[i][j] <= (i == j) ? COEF_ONE : '0;
            end
            shift_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_ROW0: begin
               for (int j = 0; j < AXES; j++) begin
                  coef_ff[0][j] <= csr_wdata[j*COEF_WIDTH +: COEF_WIDTH];
               end
            end
            CSR_ROW1: begin
               for (int j = 0; j < AXES; j++) begin
                  coef_ff[1][j] <= csr_wdata[j*COEF_WIDTH +: COEF_WIDTH];
               end
            end
            CSR_ROW2: begin
               for (int j = 0; j < AXES; j++) begin
                  coef_ff[2][j] <= csr_wdata[j*COEF_WIDTH +: COEF_WIDTH];
               end
            end
            CSR_SHIFT_X: shift_ff[0] <= csr_wdata[COORD_WIDTH-1:0];
            CSR_SHIFT_Y: shift_ff[1] <= csr_wdata[COORD_WIDTH-1:0];
            CSR_SHIFT_Z: shift_ff[2] <= csr_wdata[COORD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // A stage takes a beat when it is empty or its own beat moves on.
   assign rdy4 = !v4_ff || rsp_ch.ready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_ch.ready = rdy1;

   assign load1     = rdy1 && req_ch.valid;
   assign ctl.load2 = rdy2 && v1_ff;
   assign ctl.load3 = rdy3 && v2_ff;
   assign ctl.load4 = rdy4 && v3_ff;

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_ch.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (load1) begin
         lo_ff[0] <= req_ch.data.box_min_x;
         lo_ff[1] <= req_ch.data.box_min_y;
         lo_ff[2] <= req_ch.data.box_min_z;
         hi_ff[0] <= req_ch.data.box_max_x;
         hi_ff[1] <= req_ch.data.box_max_y;
         hi_ff[2] <= req_ch.data.box_max_z;
      end
   end

   // One datapath per output axis, fed by its matrix column.
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         for (int j = 0; j < AXES; j++) begin
            col[j][i] = coef_ff[i][j];
         end
      end
   end

   for (genvar j = 0; j < AXES; j++) begin : g_axis
      aabbxf_axis u_axis (
         .clock   (clock),
         .ctl     (ctl),
         .lo      (lo_ff),
         .hi      (hi_ff),
         .coef    (col[j]),
         .shift   (shift_ff[j]),
         .out_min (out_min[j]),
         .out_max (out_max[j])
      );
   end

   // Response beat.
   assign rsp_ch.valid          = v4_ff;
   assign rsp_ch.data.out_min_x = out_min[0];
   assign rsp_ch.data.out_min_y = out_min[1];
   assign rsp_ch.data.out_min_z = out_min[2];
   assign rsp_ch.data.out_max_x = out_max[0];
   assign rsp_ch.data.out_max_y = out_max[1];
   assign rsp_ch.data.out_max_z = out_max[2];

   // The result box is always ordered, even for an inverted input box.
   a_ordered_box : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.data.out_min_x <= rsp_ch.data.out_max_x) &&
                       (rsp_ch.data.out_min_y <= rsp_ch.data.out_max_y) &&
                       (rsp_ch.data.out_min_z <= rsp_ch.data.out_max_z))
      else $error("result box has a minimum above its maximum");

   // An accepted request beat always lands in the input register.
   a_accept_fills : assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> v1_ff)
      else $error("accepted request beat was lost");

   // A beat in the product stage with a stalled pipeline ahead stays put.
   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !rdy3) |=> v2_ff)
      else $error("stalled beat dropped from product stage");

   // Reset empties the pipeline.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_ch.valid && !v1_ff)
      else $error("pipeline not empty after reset");

endmodule

// File: tb/affine_bounding_box_transform_tb.sv
// Self-checking testbench for the affine bounding box transform block.
// Needs aabbxf_pkg, the aabbxf channel interfaces and the block itself; it predicts
// each transformed box from its own copy of the matrix and translation registers.
module affine_bounding_box_transform_tb;
   import aabbxf_pkg::*;

   localparam int        SPARE_BITS   = ROW_WIDTH - COORD_WIDTH;
   localparam coord_type TOP_COORD    = coord_type'({1'b0, {(COORD_WIDTH-1){1'b1}}});
   localparam coord_type BOTTOM_COORD = coord_type'({1'b1, {(COORD_WIDTH-1){1'b0}}});
   localparam coef_type  TOP_COEF     = coef_type'({1'b0, {(COEF_WIDTH-1){1'b1}}});
   localparam coef_type  BOTTOM_COEF  = coef_type'({1'b1, {(COEF_WIDTH-1){1'b0}}});
   localparam longint    SAT_HI       = longint'(COORD_MAX);
   localparam longint    SAT_LO       = longint'(COORD_MIN);

   // Register indexes with no register behind them.
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_SPARE_B = 3'd7;

   // Coefficient styles used to build matrices.
   localparam int COEFS_SMALL   = 0;
   localparam int COEFS_FULL    = 1;
   localparam int COEFS_EXTREME = 2;
   localparam int COEFS_MIXED   = 3;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_ADDR_WIDTH-1:0] csr_addr;
   logic [ROW_WIDTH-1:0] csr_wdata;

   aabbxf_req_if req_if ();
   aabbxf_rsp_if rsp_if ();

   affine_bounding_box_transform dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the matrix rows and translation as last written.
   logic [ROW_WIDTH-1:0] row_model [AXES];
   coord_type            shift_model [AXES];

   result_type expected_boxes [$];
   result_type oldest_box;
   int         mismatches = 0;
   bit         idle_enable = 1'b1;

   always #5 clock = ~clock;

   // Transform the eight corners, saturate each, and keep the per-axis extremes.
   function automatic result_type transform_box(input box_type b);
      coord_type  lo [AXES];
      coord_type  hi [AXES];
      longint     mn [AXES];
      longint     mx [AXES];
      longint     acc;
      longint     p;
      coef_type   k;
      result_type r;
      lo[0] = b.box_min_x;
      lo[1] = b.box_min_y;
      lo[2] = b.box_min_z;
      hi[0] = b.box_max_x;
      hi[1] = b.box_max_y;
      hi[2] = b.box_max_z;
      for (int c = 0; c < 8; c++) begin
         for (int j = 0; j < AXES; j++) begin
            acc = longint'(shift_model[j]);
            for (int i = 0; i < AXES; i++) begin
               p = ((c >> i) & 1) ? longint'(hi[i]) : longint'(lo[i]);
               k = coef_type'(row_model[i][j*COEF_WIDTH +: COEF_WIDTH]);
               acc += (p * longint'(k)) >>> FRAC_BITS;
            end
            if (acc > SAT_HI) begin
               acc = SAT_HI;
            end else if (acc < SAT_LO) begin
               acc = SAT_LO;
            end
            if (c == 0 || acc < mn[j]) mn[j] = acc;
            if (c == 0 || acc > mx[j]) mx[j] = acc;
         end
      end
      r.out_min_x = coord_type'(mn[0]);
      r.out_min_y = coord_type'(mn[1]);
      r.out_min_z = coord_type'(mn[2]);
      r.out_max_x = coord_type'(mx[0]);
      r.out_max_y = coord_type'(mx[1]);
      r.out_max_z = coord_type'(mx[2]);
      return r;
   endfunction

   // The x coefficient sits in the low bits of a row.
   function automatic logic [ROW_WIDTH-1:0] pack_row(input coef_type cx, cy, cz);
      return {cz, cy, cx};
   endfunction

   function automatic coord_type random_coord();
      case ($urandom_range(0, 7))
         0, 1: return coord_type'($urandom);
         2: begin
            case ($urandom_range(0, 2))
               0: return TOP_COORD;
               1: return BOTTOM_COORD;
               default: return '0;
            endcase
         end
         3: return coord_type'(int'($urandom_range(0, 1 << 29)) - (1 << 28));
         default: return coord_type'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
      endcase
   endfunction

   function automatic coef_type random_coef(input int style);
      int pick;
      pick = (style == COEFS_MIXED) ? $urandom_range(COEFS_SMALL, COEFS_EXTREME) : style;
      if (pick == COEFS_FULL) begin
         return coef_type'($urandom);
      end else if (pick == COEFS_EXTREME) begin
         case ($urandom_range(0, 4))
            0: return TOP_COEF;
            1: return BOTTOM_COEF;
            2: return COEF_ONE;
            3: return -COEF_ONE;
            default: return '0;
         endcase
      end
      // Within plus or minus 2.0.
      return coef_type'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
   endfunction

   function automatic box_type random_box();
      return box_type'{random_coord(), random_coord(), random_coord(),
                       random_coord(), random_coord(), random_coord()};
   endfunction

   task automatic flag_mismatch(input string what);
      if (mismatches < 50) $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   task automatic compare_coord(input string field, input coord_type got, want);
      if (got !== want) begin
         flag_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
      end
   endtask

   // Send one box beat, with an optional gap first; valid stays high afterwards.
   task automatic send_box(input box_type b);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= b;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      expected_boxes.push_back(transform_box(b));
   endtask

   // Stop sending and wait until every expected box has come back.
   task automatic drain_boxes();
      req_if.valid <= 1'b0;
      while (expected_boxes.size() != 0) @(posedge clock);
   endtask

   // One register write per cycle; the caller lowers the write enable.
   task automatic write_csr(input logic [CSR_ADDR_WIDTH-1:0] index,
                            input logic [ROW_WIDTH-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_ROW0:    row_model[0] = value;
         CSR_ROW1:    row_model[1] = value;
         CSR_ROW2:    row_model[2] = value;
         CSR_SHIFT_X: shift_model[0] = value[COORD_WIDTH-1:0];
         CSR_SHIFT_Y: shift_model[1] = value[COORD_WIDTH-1:0];
         CSR_SHIFT_Z: shift_model[2] = value[COORD_WIDTH-1:0];
         default: ;
      endcase
   endtask

   // Load a full matrix and translation once the pipeline is empty.
   // The shifts carry random junk above their 32 bits, which must be dropped.
   task automatic apply_settings(input logic [ROW_WIDTH-1:0] r0, r1, r2,
                                 input coord_type sx, sy, sz);
      drain_boxes();
      write_csr(CSR_ROW0, r0);
      write_csr(CSR_ROW1, r1);
      write_csr(CSR_ROW2, r2);
      write_csr(CSR_SHIFT_X, {SPARE_BITS'($urandom), sx});
      write_csr(CSR_SHIFT_Y, {SPARE_BITS'($urandom), sy});
      write_csr(CSR_SHIFT_Z, {SPARE_BITS'($urandom), sz});
      csr_we <= 1'b0;
   endtask

   // Identity matrix and zero translation straight out of reset.
   task automatic test_reset_identity();
      send_box(box_type'{'0, '0, '0, '0, '0, '0});
      send_box(box_type'{BOTTOM_COORD, BOTTOM_COORD, BOTTOM_COORD,
                         TOP_COORD, TOP_COORD, TOP_COORD});
      // Inverted box: minimum above maximum on every axis.
      send_box(box_type'{32'sh0005_0000, 32'sh0005_0000, 32'sh0005_0000,
                         -32'sh0003_0000, -32'sh0003_0000, -32'sh0003_0000});
      send_box(box_type'{-32'sh0001_8000, -32'sh0000_0001, 32'sh0000_0001,
                         32'sh0001_8000, 32'sh0000_0001, -32'sh0000_0001});
      send_box(box_type'{TOP_COORD, BOTTOM_COORD, '0, BOTTOM_COORD, TOP_COORD, '0});
   endtask

   // Axis permutation with a sign flip, junk in the shift upper bits, and
   // writes to indexes that hold no register.
   task automatic test_register_writes();
      apply_settings(pack_row('0, COEF_ONE, '0), pack_row('0, '0, -COEF_ONE),
                     pack_row(COEF_ONE >>> 1, '0, '0),
                     32'sh0010_0000, -32'sh0020_0000, TOP_COORD);
      // The write port goes quiet before the spare writes.
      @(posedge clock);
      write_csr(CSR_SPARE_A, '1);
      write_csr(CSR_SPARE_B, {SPARE_BITS'($urandom), 32'($urandom)});
      csr_we <= 1'b0;
      send_box(box_type'{-32'sh0002_0000, 32'sh0000_8000, 32'sh0007_0000,
                         32'sh0003_0000, 32'sh0001_0000, -32'sh0001_0000});
      send_box(box_type'{BOTTOM_COORD, BOTTOM_COORD, BOTTOM_COORD,
                         TOP_COORD, TOP_COORD, TOP_COORD});
      send_box(box_type'{'0, '0, '0, '0, '0, '0});
      send_box(box_type'{32'sh0000_0003, -32'sh0000_0003, 32'sh0000_0001,
                         -32'sh0000_0001, 32'sh0000_0005, -32'sh0000_0007});
   endtask

   // Largest and smallest coefficients and translations drive the extreme
   // boxes into saturation on both sides.
   task automatic test_saturation();
      box_type corner_cases [4];
      corner_cases[0] = box_type'{BOTTOM_COORD, BOTTOM_COORD, BOTTOM_COORD,
                                  TOP_COORD, TOP_COORD, TOP_COORD};
      corner_cases[1] = box_type'{TOP_COORD, TOP_COORD, TOP_COORD,
                                  TOP_COORD, TOP_COORD, TOP_COORD};
      corner_cases[2] = box_type'{BOTTOM_COORD, BOTTOM_COORD, BOTTOM_COORD,
                                  BOTTOM_COORD, BOTTOM_COORD, BOTTOM_COORD};
      corner_cases[3] = box_type'{-32'sh0000_0001, '0, 32'sh0000_0001,
                                  32'sh0000_0001, '0, -32'sh0000_0001};
      apply_settings(pack_row(TOP_COEF, TOP_COEF, TOP_COEF),
                     pack_row(TOP_COEF, TOP_COEF, TOP_COEF),
                     pack_row(TOP_COEF, TOP_COEF, TOP_COEF),
                     TOP_COORD, TOP_COORD, TOP_COORD);
      foreach (corner_cases[n]) send_box(corner_cases[n]);
      apply_settings(pack_row(BOTTOM_COEF, BOTTOM_COEF, BOTTOM_COEF),
                     pack_row(BOTTOM_COEF, BOTTOM_COEF, BOTTOM_COEF),
                     pack_row(BOTTOM_COEF, BOTTOM_COEF, BOTTOM_COEF),
                     BOTTOM_COORD, BOTTOM_COORD, BOTTOM_COORD);
      foreach (corner_cases[n]) send_box(corner_cases[n]);
   endtask

   // Random boxes under several random matrices; the last phase runs without
   // any idling, and one phase pauses halfway until the pipeline is empty.
   task automatic test_random_traffic();
      int style;
      for (int phase = 0; phase < 5; phase++) begin
         style = (phase == 4) ? COEFS_MIXED : phase % 3;
         apply_settings(pack_row(random_coef(style), random_coef(style), random_coef(style)),
                        pack_row(random_coef(style), random_coef(style), random_coef(style)),
                        pack_row(random_coef(style), random_coef(style), random_coef(style)),
                        random_coord(), random_coord(), random_coord());
         for (int n = 0; n < 150; n++) begin
            if (n % 30 == 0) idle_enable = (phase != 4) && ($urandom_range(0, 3) != 0);
            if (phase == 1 && n == 75) drain_boxes();
            send_box(random_box());
         end
      end
   endtask

   // Receiver side: ready with random stall bursts while idling is enabled.
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (idle_enable && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   // Compare each accepted result beat with the oldest expected box.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_boxes.size() == 0) begin
            flag_mismatch("result beat with no box outstanding");
         end else begin
            oldest_box = expected_boxes.pop_front();
            compare_coord("out_min_x", rsp_if.data.out_min_x, oldest_box.out_min_x);
            compare_coord("out_min_y", rsp_if.data.out_min_y, oldest_box.out_min_y);
            compare_coord("out_min_z", rsp_if.data.out_min_z, oldest_box.out_min_z);
            compare_coord("out_max_x", rsp_if.data.out_max_x, oldest_box.out_max_x);
            compare_coord("out_max_y", rsp_if.data.out_max_y, oldest_box.out_max_y);
            compare_coord("out_max_z", rsp_if.data.out_max_z, oldest_box.out_max_z);
         end
      end
   end

   // Main sequence.
   initial begin
      reset        <= 1'b1;
      csr_we       <= 1'b0;
      csr_addr     <= '0;
      csr_wdata    <= '0;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      for (int i = 0; i < AXES; i++) begin
         row_model[i] = '0;
         row_model[i][i*COEF_WIDTH +: COEF_WIDTH] = COEF_ONE;
         shift_model[i] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_identity();
      test_register_writes();
      test_saturation();
      test_random_traffic();

      idle_enable = 1'b0;
      drain_boxes();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule
